FILE: design/lspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_pkg
// Shared constants, types and tables for the lidar scan packet decoder.
// ----------------------------------------------------------------------------
package lspd_pkg;

  localparam int AtanIterations = 12;
  localparam int CordicMax      = 20;
  localparam int IterW          = 5;
  localparam logic [14:0] FullTurnQ6 = 15'd23040;

  // Parse phases
  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_SYNC  = 4'd1;
  localparam logic [3:0] PH_TYPE  = 4'd2;
  localparam logic [3:0] PH_COUNT = 4'd3;
  localparam logic [3:0] PH_FSA_L = 4'd4;
  localparam logic [3:0] PH_FSA_H = 4'd5;
  localparam logic [3:0] PH_LSA_L = 4'd6;
  localparam logic [3:0] PH_LSA_H = 4'd7;
  localparam logic [3:0] PH_CS_L  = 4'd8;
  localparam logic [3:0] PH_CS_H  = 4'd9;
  localparam logic [3:0] PH_SMP_L = 4'd10;
  localparam logic [3:0] PH_SMP_H = 4'd11;

  localparam logic CFG_RX_EN  = 1'b0;
  localparam logic CFG_COR_EN = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic start;    // begin sample computation on latched word
    logic step_div; // one divider iteration
    logic step_cor; // one cordic iteration
    logic finish;   // load output register
  } lspd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
  } lspd_sts_t;

  function automatic logic [35:0] atan_entry(input logic [IterW-1:0] i);
    logic [35:0] v;
    v = '0;
    case (i)
      5'd0:  v = 36'd2949120;
      5'd1:  v = 36'd1740967;
      5'd2:  v = 36'd919879;
      5'd3:  v = 36'd466945;
      5'd4:  v = 36'd234379;
      5'd5:  v = 36'd117304;
      5'd6:  v = 36'd58666;
      5'd7:  v = 36'd29335;
      5'd8:  v = 36'd14668;
      5'd9:  v = 36'd7334;
      5'd10: v = 36'd3667;
      5'd11: v = 36'd1833;
      5'd12: v = 36'd917;
      5'd13: v = 36'd458;
      5'd14: v = 36'd229;
      5'd15: v = 36'd115;
      5'd16: v = 36'd57;
      5'd17: v = 36'd29;
      5'd18: v = 36'd14;
      5'd19: v = 36'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/lspd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_datapath
// Header field registers, checksum, angle interpolation divider and cordic.
// ----------------------------------------------------------------------------
module lspd_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [3:0]         phase,
  input  wire logic               byte_take,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               cor_en,
  input  wire lspd_pkg::lspd_cmd_t cmd,
  output lspd_pkg::lspd_sts_t     sts,
  output logic                    last_now,
  output logic [14:0]             angle_q6,
  output logic [15:0]             distance_q2,
  output logic [7:0]              sample_index,
  output logic                    last_sample,
  output logic                    checksum_ok
);

  logic [7:0]  low_r, nsmp_r, idx_r;
  logic [14:0] start_r, span_r;
  logic [15:0] exp_r, csum_r, word_r;
  logic [15:0] word;
  logic [14:0] ang_w;
  logic [14:0] end_w;

  // divider: (span*idx*2 + d) / (2d), restoring, 24-bit dividend
  logic [23:0] quo_r;
  logic [8:0]  rem_r;
  logic [4:0]  dcnt_r;
  logic [8:0]  dsor;
  logic [9:0]  rtry;

  // cordic
  logic signed [35:0] x_r, y_r, z_r;
  logic [4:0]          ccnt_r;

  assign word = {rx_byte, low_r};

  function automatic logic [14:0] ang_of(input logic [15:0] w);
    logic [14:0] a;
    a = w[15:1];
    if (a >= lspd_pkg::FullTurnQ6) a = a - lspd_pkg::FullTurnQ6;
    return a;
  endfunction

  assign end_w = ang_of(word);
  assign dsor  = {nsmp_r - 8'd1, 1'b0};

  // Flag the final sample of the packet
  assign last_now = (9'(idx_r) + 9'd1 >= 9'(nsmp_r));

  // Capture header fields and sample words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r   <= '0;
      nsmp_r  <= '0;
      idx_r   <= '0;
      start_r <= '0;
      span_r  <= '0;
      exp_r   <= '0;
      csum_r  <= '0;
      word_r  <= '0;
    end else begin
      if (byte_take) begin
        case (phase)
          lspd_pkg::PH_SYNC: if (rx_byte == 8'h55) csum_r <= 16'h55AA;
          lspd_pkg::PH_TYPE, lspd_pkg::PH_FSA_L, lspd_pkg::PH_LSA_L,
          lspd_pkg::PH_CS_L, lspd_pkg::PH_SMP_L: low_r <= rx_byte;
          lspd_pkg::PH_COUNT: begin
            nsmp_r <= rx_byte;
            idx_r  <= 8'd0;
            csum_r <= csum_r ^ word;
          end
          lspd_pkg::PH_FSA_H: begin
            csum_r  <= csum_r ^ word;
            start_r <= end_w;
          end
          lspd_pkg::PH_LSA_H: begin
            csum_r <= csum_r ^ word;
            span_r <= (end_w >= start_r) ? end_w - start_r
                                         : end_w + lspd_pkg::FullTurnQ6 - start_r;
          end
          lspd_pkg::PH_CS_H: exp_r <= word;
          lspd_pkg::PH_SMP_H: begin
            csum_r <= csum_r ^ word;
            word_r <= word;
          end
          default: ;
        endcase
      end
      if (cmd.finish) idx_r <= idx_r + 8'd1;
    end
  end

  // Division start and steps
  assign rtry = {rem_r, quo_r[23]} - {1'b0, dsor};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.start) begin
      quo_r  <= 24'(span_r * idx_r * 2) + 24'(dsor[8:1]);
      rem_r  <= '0;
      dcnt_r <= 5'd24;
    end else if (cmd.step_div && dcnt_r != 5'd0) begin
      if (!rtry[9]) begin
        rem_r <= rtry[8:0];
        quo_r <= {quo_r[22:0], 1'b1};
      end else begin
        rem_r <= {rem_r[7:0], quo_r[23]};
        quo_r <= {quo_r[22:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 5'd1;
    end
  end

  // Cordic vectoring, one iteration per cycle while step_cor is asserted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
    end else if (cmd.start) begin
      x_r    <= 36'sd15530 * $signed({20'd0, word_r});
      y_r    <= 36'sd218 * (36'sd6212 - 36'sd10 * $signed({20'd0, word_r}));
      z_r    <= '0;
      ccnt_r <= '0;
    end else if (cmd.step_cor && !sts.cor_done) begin
      if (y_r > 0) begin
        x_r <= x_r + (y_r >>> ccnt_r);
        y_r <= y_r - (x_r >>> ccnt_r);
        z_r <= z_r + $signed(lspd_pkg::atan_entry(ccnt_r));
      end else begin
        x_r <= x_r - (y_r >>> ccnt_r);
        y_r <= y_r + (x_r >>> ccnt_r);
        z_r <= z_r - $signed(lspd_pkg::atan_entry(ccnt_r));
      end
      ccnt_r <= ccnt_r + 5'd1;
    end
  end

  assign sts.div_done = (dcnt_r == 5'd0);
  assign sts.cor_done = (ccnt_r >= 5'(lspd_pkg::AtanIterations)) ||
                        (ccnt_r >= 5'(lspd_pkg::CordicMax));

  // Combine interpolation and correction
  logic [15:0] base;
  logic signed [36:0] zr;
  logic signed [17:0] corr, sum;
  always_comb begin
    base = {1'b0, start_r};
    if (nsmp_r > 8'd1) base = base + {1'b0, quo_r[14:0]};
    if (base >= {1'b0, lspd_pkg::FullTurnQ6}) base = base - {1'b0, lspd_pkg::FullTurnQ6};
    zr   = ($signed({z_r[35], z_r}) + 37'sd512) >>> 10;
    corr = zr[17:0];
    sum  = $signed({2'b00, base}) ;
    if (cor_en && word_r != 16'd0) begin
      sum = sum + corr;
      if (sum < 0) sum = sum + 18'sd23040;
      else if (sum >= 18'sd23040) sum = sum - 18'sd23040;
    end
    ang_w = sum[14:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      angle_q6     <= ang_w;
      distance_q2  <= word_r;
      sample_index <= idx_r;
      last_sample  <= last_now;
      checksum_ok  <= last_now && (csum_r == exp_r);
    end
  end

endmodule
`default_nettype wire

FILE: design/lspd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_ctrl
// Parse sequencer and compute/output control.
// ----------------------------------------------------------------------------
module lspd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                rx_en,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               phase,
  output logic                     byte_take,
  output lspd_pkg::lspd_cmd_t      cmd,
  input  wire lspd_pkg::lspd_sts_t sts,
  input  wire logic                last_now
);

  localparam logic [1:0] S_PARSE = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic       ov_r, ov_nxt;
  logic       go_r;

  assign phase     = ph_r;
  assign out_valid = ov_r;
  // Accept bytes while parsing; a pending result blocks the next compute only
  assign in_ready  = (st_r == S_PARSE) &&
                     !(ph_r == lspd_pkg::PH_SMP_H && ov_r && rx_en);
  assign byte_take = in_valid && in_ready && rx_en;

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.start = go_r;
    if (in_valid && in_ready && !rx_en) ph_nxt = lspd_pkg::PH_HUNT;
    unique case (st_r)
      S_PARSE: begin
        if (byte_take) begin
          unique case (ph_r)
            lspd_pkg::PH_HUNT: if (rx_byte == 8'hAA) ph_nxt = lspd_pkg::PH_SYNC;
            lspd_pkg::PH_SYNC: begin
              if (rx_byte == 8'h55) ph_nxt = lspd_pkg::PH_TYPE;
              else if (rx_byte != 8'hAA) ph_nxt = lspd_pkg::PH_HUNT;
            end
            lspd_pkg::PH_TYPE:
              ph_nxt = (rx_byte != 8'd0) ? lspd_pkg::PH_HUNT : lspd_pkg::PH_COUNT;
            lspd_pkg::PH_COUNT:
              ph_nxt = (rx_byte == 8'd0) ? lspd_pkg::PH_HUNT : lspd_pkg::PH_FSA_L;
            lspd_pkg::PH_FSA_L, lspd_pkg::PH_FSA_H, lspd_pkg::PH_LSA_L,
            lspd_pkg::PH_LSA_H, lspd_pkg::PH_CS_L, lspd_pkg::PH_CS_H,
            lspd_pkg::PH_SMP_L: ph_nxt = ph_r + 4'd1;
            lspd_pkg::PH_SMP_H: st_nxt = S_CALC;
            default: ph_nxt = lspd_pkg::PH_HUNT;
          endcase
        end
      end
      S_CALC: begin
        // Hold off iteration the cycle start loads the units
        if (!go_r) begin
          cmd.step_div = 1'b1;
          cmd.step_cor = 1'b1;
          if (sts.div_done && sts.cor_done) begin
            cmd.finish = 1'b1;
            ov_nxt     = 1'b1;
            st_nxt     = S_PARSE;
            ph_nxt     = last_now ? lspd_pkg::PH_HUNT : lspd_pkg::PH_SMP_L;
          end
        end
      end
      default: st_nxt = S_PARSE;
    endcase
  end

  // Start compute in the cycle after the high byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_PARSE;
      ph_r <= lspd_pkg::PH_HUNT;
      ov_r <= 1'b0;
      go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      ov_r <= ov_nxt;
      go_r <= byte_take && ph_r == lspd_pkg::PH_SMP_H;
    end
  end

endmodule
`default_nettype wire

FILE: design/lidar_scan_packet_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder
// Parses lidar scan packets byte by byte and emits one angle/distance result
// per sample word.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_      input      rx_byte
// out_     output     angle_q6, distance_q2, sample_index, last_sample,
//                     checksum_ok
// cfg_     input      index 0 receive_enable, 1 correction_enable
//
// Header and low bytes are accepted whenever the parser is ready. A sample high
// byte starts a 24-step divider and a 12-step cordic in parallel; the result is
// registered once both finish, and input is held during the compute, so the next
// byte is taken only after the result is loaded.
// Reset is synchronous; both enables reset to 1.
// A result held by out_ready stalls only the next sample's high byte.
// ----------------------------------------------------------------------------
module lidar_scan_packet_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      out_angle_q6,
  output logic [15:0]      out_distance_q2,
  output logic [7:0]       out_sample_index,
  output logic             out_last_sample,
  output logic             out_checksum_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  logic rx_en_r, cor_en_r;
  logic [3:0] phase;
  logic byte_take;
  logic last_now;
  lspd_pkg::lspd_cmd_t cmd;
  lspd_pkg::lspd_sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_en_r  <= 1'b1;
      cor_en_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == lspd_pkg::CFG_RX_EN) rx_en_r <= cfg_data;
      else cor_en_r <= cfg_data;
    end
  end

  lspd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .rx_byte(in_rx_byte), .rx_en(rx_en_r),
    .out_valid, .out_ready, .phase, .byte_take, .cmd(cmd), .sts(sts),
    .last_now(last_now)
  );

  lspd_datapath u_dp (
    .clk, .rst_n, .phase, .byte_take, .rx_byte(in_rx_byte), .cor_en(cor_en_r),
    .cmd(cmd), .sts, .last_now(last_now),
    .angle_q6(out_angle_q6), .distance_q2(out_distance_q2),
    .sample_index(out_sample_index), .last_sample(out_last_sample),
    .checksum_ok(out_checksum_ok)
  );

endmodule
`default_nettype wire

FILE: tb/sv/lspd_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_scoreboard
// Watches the byte, result and register channels of the scan packet decoder,
// tracks its own copy of the parser and the arithmetic, and compares every
// result taken from the decoder against the oldest predicted sample.
// ----------------------------------------------------------------------------
module lspd_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [14:0] out_angle_q6,
  input  logic [15:0] out_distance_q2,
  input  logic [7:0]  out_sample_index,
  input  logic        out_last_sample,
  input  logic        out_checksum_ok,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  output int          fail_count,
  output int          pending_samples
);

  typedef struct packed {
    logic [14:0] angle_q6;
    logic [15:0] distance_q2;
    logic [7:0]  sample_index;
    logic        last_sample;
    logic        checksum_ok;
  } sample_t;

  sample_t     sample_q[$];

  // Tracked decoder state
  logic        rx_en;
  logic        cor_en;
  logic [3:0]  phase;
  logic [7:0]  pkt_len;
  logic [7:0]  smp_cnt;
  logic [7:0]  lo_byte;
  logic [14:0] fsa_q6;
  logic [14:0] span_q6;
  logic [15:0] cs_want;
  logic [15:0] cs_run;

  localparam longint AtanTab [20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  function automatic logic [14:0] word_to_q6(input logic [15:0] w);
    logic [14:0] a;
    a = w[15:1];
    if (a >= 15'd23040) a = a - 15'd23040;
    return a;
  endfunction

  // Vectoring rotation toward the x axis; angle in degrees * 65536
  function automatic int atan_correction_q6(input logic [15:0] raw);
    longint x, y, z, dx, dy;
    x = 64'sd15530 * longint'(raw);
    y = 64'sd218 * (64'sd6212 - 64'sd10 * longint'(raw));
    z = 0;
    for (int i = 0; i < lspd_pkg::AtanIterations && i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + AtanTab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - AtanTab[i];
      end
    end
    return int'((z + 512) >>> 10);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("lspd_scoreboard: %s mismatch at %0t: got %0d want %0d",
             what, $time, got, want);
    fail_count++;
  endtask

  // Advance the tracked parser by one accepted byte
  task automatic decode_byte(input logic [7:0] b);
    logic [15:0] word;
    logic [14:0] end_q6;
    int          ang;
    int          d;
    sample_t     s;
    word = {b, lo_byte};
    if (!rx_en) begin
      phase = lspd_pkg::PH_HUNT;
      return;
    end
    case (phase)
      lspd_pkg::PH_HUNT: if (b == 8'hAA) phase = lspd_pkg::PH_SYNC;
      lspd_pkg::PH_SYNC: begin
        if (b == 8'h55) begin
          cs_run = 16'h55AA;
          phase = lspd_pkg::PH_TYPE;
        end else if (b != 8'hAA) begin
          phase = lspd_pkg::PH_HUNT;
        end
      end
      lspd_pkg::PH_TYPE: begin
        lo_byte = b;
        phase = (b != 0) ? lspd_pkg::PH_HUNT : lspd_pkg::PH_COUNT;
      end
      lspd_pkg::PH_COUNT: begin
        if (b == 0) begin
          phase = lspd_pkg::PH_HUNT;
        end else begin
          pkt_len = b;
          smp_cnt = 0;
          cs_run = cs_run ^ word;
          phase = lspd_pkg::PH_FSA_L;
        end
      end
      lspd_pkg::PH_FSA_L, lspd_pkg::PH_LSA_L, lspd_pkg::PH_CS_L,
      lspd_pkg::PH_SMP_L: begin
        lo_byte = b;
        phase = phase + 4'd1;
      end
      lspd_pkg::PH_FSA_H: begin
        cs_run = cs_run ^ word;
        fsa_q6 = word_to_q6(word);
        phase = lspd_pkg::PH_LSA_L;
      end
      lspd_pkg::PH_LSA_H: begin
        end_q6 = word_to_q6(word);
        cs_run = cs_run ^ word;
        span_q6 = (end_q6 >= fsa_q6) ? end_q6 - fsa_q6 : end_q6 + 15'd23040 - fsa_q6;
        phase = lspd_pkg::PH_CS_L;
      end
      lspd_pkg::PH_CS_H: begin
        cs_want = word;
        phase = lspd_pkg::PH_SMP_L;
      end
      lspd_pkg::PH_SMP_H: begin
        cs_run = cs_run ^ word;
        ang = fsa_q6;
        if (pkt_len > 1) begin
          d = pkt_len - 1;
          ang = ang + (int'(span_q6) * int'(smp_cnt) * 2 + d) / (2 * d);
        end
        if (ang >= 23040) ang = ang - 23040;
        if (cor_en && word != 0) begin
          ang = ang + atan_correction_q6(word);
          if (ang < 0) ang = ang + 23040;
          else if (ang >= 23040) ang = ang - 23040;
        end
        s.angle_q6     = ang[14:0];
        s.distance_q2  = word;
        s.sample_index = smp_cnt;
        s.last_sample  = (int'(smp_cnt) + 1 >= int'(pkt_len));
        s.checksum_ok  = s.last_sample && (cs_run == cs_want);
        sample_q.push_back(s);
        if (s.last_sample) begin
          phase = lspd_pkg::PH_HUNT;
        end else begin
          smp_cnt = smp_cnt + 8'd1;
          phase = lspd_pkg::PH_SMP_L;
        end
      end
      default: phase = lspd_pkg::PH_HUNT;
    endcase
  endtask

  // Compare results first, then fold in the new request
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      rx_en = 1'b1; cor_en = 1'b1; phase = lspd_pkg::PH_HUNT;
      pkt_len = 0; smp_cnt = 0; lo_byte = 0; fsa_q6 = 0; span_q6 = 0;
      cs_want = 0; cs_run = 0;
      sample_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected sample", out_sample_index, -1);
        end else begin
          want = sample_q.pop_front();
          if (out_angle_q6 != want.angle_q6)
            report_mismatch("angle_q6", out_angle_q6, want.angle_q6);
          if (out_distance_q2 != want.distance_q2)
            report_mismatch("distance_q2", out_distance_q2, want.distance_q2);
          if (out_sample_index != want.sample_index)
            report_mismatch("sample_index", out_sample_index, want.sample_index);
          if (out_last_sample != want.last_sample)
            report_mismatch("last_sample", out_last_sample, want.last_sample);
          if (out_checksum_ok != want.checksum_ok)
            report_mismatch("checksum_ok", out_checksum_ok, want.checksum_ok);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lspd_pkg::CFG_RX_EN) rx_en = cfg_data;
        else cor_en = cfg_data;
      end
      if (in_valid && in_ready) decode_byte(in_rx_byte);
    end
    pending_samples = sample_q.size();
  end

  initial begin
    fail_count = 0;
    pending_samples = 0;
  end

endmodule

FILE: tb/sv/tb_lidar_scan_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_scan_packet_decoder
// Drives lidar byte streams into the scan packet decoder: directed header,
// drop and wrap cases, then random packets and noise under three idling
// mixes, with register changes between phases and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lidar_scan_packet_decoder;

  localparam int CycleLimit = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] out_angle_q6;
  logic [15:0] out_distance_q2;
  logic [7:0]  out_sample_index;
  logic        out_last_sample;
  logic        out_checksum_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic        cfg_data;
  int          fail_count;
  int          pending_samples;
  int          cycle_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          bytes_sent;

  lidar_scan_packet_decoder i_dut (.*);

  lspd_scoreboard i_scoreboard (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_lidar_scan_packet_decoder: done, errors");
      $finish;
    end
  end

  // Receiver: random idling plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and let the decoder drain before a register write
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_samples != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_distance();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 40));
      3: return 16'($urandom_range(560, 680));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a full packet; bad_cs flips the checksum word
  task automatic send_packet(input logic [7:0] ct, input logic [7:0] n,
                             input logic [15:0] fsa, input logic [15:0] lsa,
                             input logic bad_cs);
    logic [15:0] cs;
    logic [15:0] smp [256];
    cs = 16'h55AA ^ {n, ct} ^ fsa ^ lsa;
    for (int i = 0; i < n; i++) begin
      smp[i] = rand_distance();
      cs = cs ^ smp[i];
    end
    if (bad_cs) cs = cs ^ 16'($urandom_range(1, 65535));
    push_byte(8'hAA); push_byte(8'h55); push_byte(ct); push_byte(n);
    push_byte(fsa[7:0]); push_byte(fsa[15:8]);
    push_byte(lsa[7:0]); push_byte(lsa[15:8]);
    push_byte(cs[7:0]); push_byte(cs[15:8]);
    for (int i = 0; i < n; i++) begin
      push_byte(smp[i][7:0]);
      push_byte(smp[i][15:8]);
    end
  endtask

  task automatic random_phase(input int nbytes);
    int stop_at;
    int k;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      k = $urandom_range(99);
      if (k < 70) begin
        send_packet(8'h00, 8'($urandom_range(1, 8)), 16'($urandom), 16'($urandom),
                    $urandom_range(3) == 0);
      end else if (k < 80) begin
        push_byte(8'($urandom));
      end else if (k < 88) begin
        push_byte(8'hAA); push_byte(8'h55);
        push_byte(8'($urandom_range(1, 255)));
      end else if (k < 94) begin
        push_byte(8'hAA);
        push_byte($urandom_range(1) ? 8'hAA : 8'($urandom));
      end else begin
        // Truncated header followed by whatever comes next
        push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00);
        push_byte(8'($urandom_range(1, 4))); push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = lspd_pkg::CFG_RX_EN;
    cfg_data = 1'b0;
    out_ready = 1'b0;
    cycle_cnt = 0;
    hold_cycles = 0;
    bytes_sent = 0;
    send_idle_pct = 15;
    recv_idle_pct = 82;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: repeated header byte, broken header, drops
    push_byte(8'hAA); push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00);
    push_byte(8'h01); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h00); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hAA); push_byte(8'h12);
    push_byte(8'hAA); push_byte(8'h55); push_byte(8'h01);
    push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00); push_byte(8'h00);
    // Single sample, angle words past a full turn, start above end
    send_packet(8'h00, 8'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    send_packet(8'h00, 8'd3, 16'hB000, 16'h0010, 1'b0);
    send_packet(8'h00, 8'd255, 16'h0000, 16'hB3FF, 1'b0);

    // Disable in the middle of a packet, then restore
    push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00); push_byte(8'h04);
    push_byte(8'h10);
    write_reg(lspd_pkg::CFG_RX_EN, 1'b0);
    push_byte(8'hAA); push_byte(8'h55); push_byte(8'h00); push_byte(8'hFF);
    write_reg(lspd_pkg::CFG_RX_EN, 1'b1);
    write_reg(lspd_pkg::CFG_COR_EN, 1'b0);
    send_packet(8'h00, 8'd2, 16'h0000, 16'hFFFF, 1'b0);
    write_reg(lspd_pkg::CFG_COR_EN, 1'b1);

    random_phase(150);

    write_reg(lspd_pkg::CFG_COR_EN, 1'b0);
    send_idle_pct = 82;
    recv_idle_pct = 15;
    random_phase(150);

    write_reg(lspd_pkg::CFG_COR_EN, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Stall the receiver so the decoder backs up its input
    hold_cycles = 600;
    random_phase(150);

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_lidar_scan_packet_decoder: done, clean");
    end else begin
      $display("tb_lidar_scan_packet_decoder: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/lspd_pkg.sv
design/lspd_datapath.sv
design/lspd_ctrl.sv
design/lidar_scan_packet_decoder.sv
tb/sv/lspd_scoreboard.sv
tb/sv/tb_lidar_scan_packet_decoder.sv
